@@ design/assert_macros.svh @@
// Assertion macros used by the ALU core top level.
// Included by name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_PROP(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

@@ design/vtia_pkg.sv @@
// Shared types and codes of the typed 64-bit ALU core.
// No dependencies.
package vtia_pkg;

  // Operation codes.
  typedef enum logic [3:0] {
    OP_ADD = 4'd0, OP_SUB = 4'd1, OP_MUL = 4'd2, OP_DIV = 4'd3,
    OP_REM = 4'd4, OP_NEG = 4'd5, OP_EQ = 4'd6, OP_NE = 4'd7,
    OP_LT = 4'd8, OP_LE = 4'd9, OP_GT = 4'd10, OP_GE = 4'd11,
    OP_AND = 4'd12, OP_OR = 4'd13, OP_NOT = 4'd14, OP_INVALID = 4'd15
  } func_e;

  // Operand and result type tags.
  typedef enum logic [1:0] {
    TY_VOID = 2'd0, TY_INT = 2'd1, TY_BOOL = 2'd2, TY_OTHER = 2'd3
  } tag_e;

  // Result status codes.
  typedef enum logic [1:0] {
    ST_OK = 2'd0, ST_STATE = 2'd1, ST_TYPE = 2'd2
  } status_e;

  // Control word of one classified operation.
  typedef struct packed {
    func_e   func;
    status_e status;
    logic    sign_a;
    logic    sign_b;
    logic    b_zero;
  } op_ctl_t;

  localparam int unsigned FifoDepth  = 4;

endpackage

@@ design/vtia_front.sv @@
// Front end: checks operand count and types and classifies the operation.
// Depends on vtia_pkg.
module vtia_front #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  vtia_pkg::func_e            func_i,
  input  logic [63:0]                operand_a_i,
  input  logic [63:0]                operand_b_i,
  input  logic [1:0]                 tag_a_i,
  input  logic [1:0]                 tag_b_i,
  input  logic                       plain_a_i,
  input  logic                       plain_b_i,
  input  logic [1:0]                 depth_available_i,
  output vtia_pkg::op_ctl_t          ctl_o,
  output logic [DATA_WIDTH-1:0]      a_o,
  output logic [DATA_WIDTH-1:0]      b_o
);
  import vtia_pkg::*;

  logic [DATA_WIDTH-1:0] a_w, b_w;
  logic unary, logic_op, want_bool, depth_ok, a_ok, b_ok;
  tag_e want;

  assign a_w = operand_a_i[DATA_WIDTH-1:0];
  assign b_w = operand_b_i[DATA_WIDTH-1:0];

  // Operand requirements of the operation.
  always_comb begin
    unary     = (func_i == OP_NEG) || (func_i == OP_NOT);
    logic_op  = (func_i == OP_AND) || (func_i == OP_OR) || (func_i == OP_NOT);
    want_bool = logic_op ||
                (((func_i == OP_EQ) || (func_i == OP_NE)) && (tag_a_i == TY_BOOL));
    want      = want_bool ? TY_BOOL : TY_INT;
    depth_ok  = unary ? (depth_available_i != 2'd0) : depth_available_i[1];
    a_ok      = (tag_a_i == want) && plain_a_i &&
                (!want_bool || (a_w[DATA_WIDTH-1:1] == '0));
    b_ok      = (tag_b_i == want) && plain_b_i &&
                (!want_bool || (b_w[DATA_WIDTH-1:1] == '0));
  end

  // Status in check order: count, types, then opcode.
  always_comb begin
    ctl_o.func   = func_i;
    ctl_o.sign_a = a_w[DATA_WIDTH-1];
    ctl_o.sign_b = unary ? 1'b0 : b_w[DATA_WIDTH-1];
    ctl_o.b_zero = unary || (b_w == '0);
    if (!depth_ok) begin
      ctl_o.status = ST_STATE;
    end else if (!a_ok || (!unary && !b_ok)) begin
      ctl_o.status = ST_TYPE;
    end else if (func_i == OP_INVALID) begin
      ctl_o.status = ST_STATE;
    end else begin
      ctl_o.status = ST_OK;
    end
    a_o = a_w;
    b_o = unary ? '0 : b_w;
  end

endmodule

@@ design/vtia_fifo.sv @@
// Short register queue between the front end and the execution pipeline.
// Depends on vtia_pkg.
module vtia_fifo #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  vtia_pkg::op_ctl_t      ctl_i,
  input  logic [DATA_WIDTH-1:0]  a_i,
  input  logic [DATA_WIDTH-1:0]  b_i,
  output logic                   full_o,
  output logic                   valid_o,
  input  logic                   pop_i,
  output vtia_pkg::op_ctl_t      ctl_o,
  output logic [DATA_WIDTH-1:0]  a_o,
  output logic [DATA_WIDTH-1:0]  b_o
);
  import vtia_pkg::*;

  localparam int unsigned PtrW = $clog2(FifoDepth);

  op_ctl_t               ctl_mem [FifoDepth];
  logic [DATA_WIDTH-1:0] a_mem   [FifoDepth];
  logic [DATA_WIDTH-1:0] b_mem   [FifoDepth];
  logic [PtrW-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [PtrW:0]         count_q, count_d;
  logic                  do_push, do_pop;

  assign full_o  = (count_q == (PtrW+1)'(FifoDepth));
  assign valid_o = (count_q != '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = do_push ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = do_pop ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q + (PtrW+1)'(do_push) - (PtrW+1)'(do_pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage write.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ctl_mem[wr_ptr_q] <= ctl_i;
      a_mem[wr_ptr_q]   <= a_i;
      b_mem[wr_ptr_q]   <= b_i;
    end
  end

  assign ctl_o = ctl_mem[rd_ptr_q];
  assign a_o   = a_mem[rd_ptr_q];
  assign b_o   = b_mem[rd_ptr_q];

endmodule

@@ design/vtia_back.sv @@
// Execution pipeline: simple ops, split multiplier, one-bit-per-stage divider,
// and the output register. Depends on vtia_pkg.
module vtia_back #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  vtia_pkg::op_ctl_t      ctl_i,
  input  logic [DATA_WIDTH-1:0]  a_i,
  input  logic [DATA_WIDTH-1:0]  b_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [63:0]            result_value_o,
  output logic [1:0]             result_tag_o,
  output logic [1:0]             status_o
);
  import vtia_pkg::*;

  localparam int unsigned W  = DATA_WIDTH;
  localparam int unsigned HW = W / 2;
  localparam int unsigned LW = W - HW;

  logic advance;

  // Stage A registers.
  logic                 va_q;
  op_ctl_t              ctla_q;
  logic [2*LW-1:0]      ll_q;
  logic [HW-1:0]        lh_q, hl_q;
  logic [W-1:0]         resa_q, ua_q, ub_q;

  // Stage B and divider chain registers; index k holds k finished steps.
  logic                 v_q   [W+1];
  op_ctl_t              ctl_q [W+1];
  logic [W-1:0]         r_q   [W+1];
  logic [W-1:0]         q_q   [W+1];
  logic [W-1:0]         d_q   [W+1];

  // Output register.
  logic                 out_valid_q;
  logic [63:0]          value_q;
  logic [1:0]           tag_q, status_q;

  logic [W-1:0]         res_a, ua_a, ub_a;
  logic [W-1:0]         lh_full, hl_full;
  logic [2*LW-1:0]      ll_full;
  logic [W-1:0]         q_b, mul_sum, final_v;
  logic [63:0]          value_d;
  logic [1:0]           tag_d;

  // The whole pipeline moves when the output register is free or drained.
  assign advance = !out_valid_q || out_ready_i;
  assign pop_o   = advance && valid_i;

  // Stage A: simple operations, operand magnitudes and partial products.
  always_comb begin
    case (ctl_i.func)
      OP_ADD:  res_a = a_i + b_i;
      OP_SUB:  res_a = a_i - b_i;
      OP_NEG:  res_a = '0 - a_i;
      OP_EQ:   res_a = W'(a_i == b_i);
      OP_NE:   res_a = W'(a_i != b_i);
      OP_LT:   res_a = W'($signed(a_i) < $signed(b_i));
      OP_LE:   res_a = W'(!($signed(b_i) < $signed(a_i)));
      OP_GT:   res_a = W'($signed(b_i) < $signed(a_i));
      OP_GE:   res_a = W'(!($signed(a_i) < $signed(b_i)));
      OP_AND:  res_a = W'((a_i != '0) && (b_i != '0));
      OP_OR:   res_a = W'((a_i != '0) || (b_i != '0));
      OP_NOT:  res_a = W'(a_i == '0);
      default: res_a = '0;
    endcase
    ua_a    = ctl_i.sign_a ? ('0 - a_i) : a_i;
    ub_a    = ctl_i.sign_b ? ('0 - b_i) : b_i;
    ll_full = {{LW{1'b0}}, a_i[LW-1:0]} * {{LW{1'b0}}, b_i[LW-1:0]};
    lh_full = {{HW{1'b0}}, a_i[LW-1:0]} * {{LW{1'b0}}, b_i[W-1:LW]};
    hl_full = {{LW{1'b0}}, a_i[W-1:LW]} * {{HW{1'b0}}, b_i[LW-1:0]};
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctla_q <= ctl_i;
      ll_q   <= ll_full;
      lh_q   <= lh_full[HW-1:0];
      hl_q   <= hl_full[HW-1:0];
      resa_q <= res_a;
      ua_q   <= ua_a;
      ub_q   <= ub_a;
    end
  end

  // Stage B: multiplier sum, divider setup.
  always_comb begin
    mul_sum = ll_q[W-1:0] + {HW'(lh_q + hl_q), {LW{1'b0}}};
    case (ctla_q.func)
      OP_MUL:  q_b = mul_sum;
      OP_DIV:  q_b = ua_q;
      OP_REM:  q_b = ua_q;
      default: q_b = resa_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      ctl_q[0] <= ctla_q;
      r_q[0]   <= '0;
      q_q[0]   <= q_b;
      d_q[0]   <= ub_q;
    end
  end

  // Divider chain: one restoring step per stage; other ops pass unchanged.
  for (genvar k = 0; k < W; k++) begin : g_div
    logic [W:0]   shifted, diff;
    logic         is_div;
    logic [W-1:0] r_next, q_next;

    always_comb begin
      is_div  = (ctl_q[k].func == OP_DIV) || (ctl_q[k].func == OP_REM);
      shifted = {r_q[k], q_q[k][W-1]};
      diff    = shifted - {1'b0, d_q[k]};
      if (!is_div) begin
        r_next = r_q[k];
        q_next = q_q[k];
      end else if (!diff[W]) begin
        r_next = diff[W-1:0];
        q_next = {q_q[k][W-2:0], 1'b1};
      end else begin
        r_next = shifted[W-1:0];
        q_next = {q_q[k][W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        ctl_q[k+1] <= ctl_q[k];
        r_q[k+1]   <= r_next;
        q_q[k+1]   <= q_next;
        d_q[k+1]   <= d_q[k];
      end
    end
  end

  // Valid bits of every stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      for (int i = 0; i <= W; i++) begin
        v_q[i] <= 1'b0;
      end
      out_valid_q <= 1'b0;
    end else if (advance) begin
      va_q <= valid_i;
      v_q[0] <= va_q;
      for (int i = 0; i < W; i++) begin
        v_q[i+1] <= v_q[i];
      end
      out_valid_q <= v_q[W];
    end
  end

  // Final select: sign fixup of quotient and remainder, error masking.
  always_comb begin
    case (ctl_q[W].func)
      OP_DIV:  final_v = ctl_q[W].b_zero ? '0 :
                         ((ctl_q[W].sign_a ^ ctl_q[W].sign_b) ? ('0 - q_q[W]) : q_q[W]);
      OP_REM:  final_v = ctl_q[W].b_zero ? '0 :
                         (ctl_q[W].sign_a ? ('0 - r_q[W]) : r_q[W]);
      default: final_v = q_q[W];
    endcase
    case (ctl_q[W].func)
      OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE, OP_AND, OP_OR, OP_NOT:
        tag_d = TY_BOOL;
      default:
        tag_d = TY_INT;
    endcase
    value_d = 64'($signed(final_v));
    if (ctl_q[W].status != ST_OK) begin
      value_d = '0;
      tag_d   = TY_INT;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      value_q  <= value_d;
      tag_q    <= tag_d;
      status_q <= ctl_q[W].status;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign result_value_o = value_q;
  assign result_tag_o   = tag_q;
  assign status_o       = status_q;

endmodule

@@ design/vm_typed_int64_alu_core.sv @@
// Channel  | Signals                      | Payload
// ---------+------------------------------+------------------------------------------
// request  | s_axis_tvalid/tready/tdata/  | operation, operands, depth; tags and
//          | tuser                        | plain flags in tuser
// result   | m_axis_tvalid/tready/tdata/  | value and status; result tag in tuser
//          | tuser                        |
// One item per cycle is accepted and delivered in steady state while the result side
// is ready. Each item passes the queue, stage A, stage B, the divider chain that retires
// one quotient bit per stage, and the output register. Reset clears the queue and all
// stage valid bits; no clearing pass. A stalled result holds the whole execution
// pipeline; the four-entry queue keeps taking requests until it fills.
// Depends on vtia_pkg, vtia_front, vtia_fifo, vtia_back and assert_macros.svh.
`include "assert_macros.svh"
module vm_typed_int64_alu_core #(
  parameter int unsigned DATA_WIDTH = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  // [3:0] func, [67:4] operand_a, [131:68] operand_b,
  // [133:132] depth_available, [135:134] zero
  input  logic [135:0]  s_axis_tdata,
  // [1:0] tag_a, [3:2] tag_b, [4] plain_a, [5] plain_b
  input  logic [5:0]    s_axis_tuser,
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [63:0] result_value, [65:64] status, [71:66] zero
  output logic [71:0]   m_axis_tdata,
  // [1:0] result_tag
  output logic [1:0]    m_axis_tuser
);
  import vtia_pkg::*;

  op_ctl_t               fe_ctl, q_ctl;
  logic [DATA_WIDTH-1:0] fe_a, fe_b, q_a, q_b;
  logic                  q_full, q_valid, q_pop;
  logic [63:0]           value;
  logic [1:0]            tag, status;
  logic                  res_err, res_bool, res_bad_code;

  // Classify the incoming request.
  vtia_front #(.DATA_WIDTH(DATA_WIDTH)) u_front (
    .func_i           (func_e'(s_axis_tdata[3:0])),
    .operand_a_i      (s_axis_tdata[67:4]),
    .operand_b_i      (s_axis_tdata[131:68]),
    .tag_a_i          (s_axis_tuser[1:0]),
    .tag_b_i          (s_axis_tuser[3:2]),
    .plain_a_i        (s_axis_tuser[4]),
    .plain_b_i        (s_axis_tuser[5]),
    .depth_available_i(s_axis_tdata[133:132]),
    .ctl_o            (fe_ctl),
    .a_o              (fe_a),
    .b_o              (fe_b)
  );

  assign s_axis_tready = !q_full;

  // Queue between front end and execution.
  vtia_fifo #(.DATA_WIDTH(DATA_WIDTH)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (s_axis_tvalid),
    .ctl_i  (fe_ctl),
    .a_i    (fe_a),
    .b_i    (fe_b),
    .full_o (q_full),
    .valid_o(q_valid),
    .pop_i  (q_pop),
    .ctl_o  (q_ctl),
    .a_o    (q_a),
    .b_o    (q_b)
  );

  // Execution pipeline with output register.
  vtia_back #(.DATA_WIDTH(DATA_WIDTH)) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (q_valid),
    .ctl_i         (q_ctl),
    .a_i           (q_a),
    .b_i           (q_b),
    .pop_o         (q_pop),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .result_value_o(value),
    .result_tag_o  (tag),
    .status_o      (status)
  );

  assign m_axis_tdata = {6'b0, status, value};
  assign m_axis_tuser = tag;

  // Result classes watched by the checks below.
  assign res_err      = m_axis_tvalid && (status != ST_OK);
  assign res_bool     = m_axis_tvalid && (tag == TY_BOOL);
  assign res_bad_code = m_axis_tvalid &&
                        (((status != ST_OK) && (status != ST_STATE) && (status != ST_TYPE)) ||
                         (tag == TY_VOID) || (tag == TY_OTHER));

  // An error result carries a zero value and the integer tag.
  `ASSERT_PROP(a_err_zero, clk_i, rst_ni, res_err |-> ((value == '0) && (tag == TY_INT)))
  // Boolean results are 0 or 1 and only come with an ok status.
  `ASSERT_PROP(a_bool_val, clk_i, rst_ni, res_bool |-> ((value[63:1] == '0) && (status == ST_OK)))
  // Status never takes the unused code and the tag is int or bool.
  `ASSERT_NEVER(a_codes, clk_i, rst_ni, res_bad_code)

endmodule

@@ tb/sv/vm_typed_int64_alu_core_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for the typed 64-bit ALU core.
// Drives request transfers, predicts each result and checks it field by field.
// Depends on vtia_pkg and vm_typed_int64_alu_core.
module vm_typed_int64_alu_core_test;
  import vtia_pkg::*;

  localparam longint unsigned MinVal   = 64'h8000_0000_0000_0000;
  localparam longint unsigned MaxVal   = 64'h7fff_ffff_ffff_ffff;
  localparam longint unsigned AllOnes  = 64'hffff_ffff_ffff_ffff;
  localparam int unsigned     DrainGap = 80;
  localparam int unsigned     HoldLength = 300;
  localparam longint          CycleLimit = 400000;

  typedef struct packed {
    logic [63:0] value;
    tag_e        tag;
    status_e     status;
  } alu_result_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [135:0] s_axis_tdata;
  logic [5:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [71:0]  m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  alu_result_t expected_results[$];
  int unsigned error_count;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_req;
  int unsigned hold_done;
  int unsigned hold_cycles;
  longint      cycle_count;

  vm_typed_int64_alu_core u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  // Clock with a 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // Checks whether an operand is a plain scalar of the wanted type.
  function automatic bit operand_qualifies(tag_e tag, logic plain, logic [63:0] val, tag_e want);
    if (tag != want || plain !== 1'b1) return 1'b0;
    if (want == TY_BOOL && val != 64'd0 && val != 64'd1) return 1'b0;
    return 1'b1;
  endfunction

  // Computes the result of one ALU operation.
  function automatic alu_result_t alu_compute(func_e op, logic [63:0] a, logic [63:0] b,
                                              tag_e ta, tag_e tb, logic pa, logic pb,
                                              logic [1:0] depth);
    alu_result_t r;
    bit          unary;
    tag_e        want;
    logic [63:0] ua;
    logic [63:0] ub;
    logic [63:0] q;
    logic [63:0] rm;
    unary = (op == OP_NEG || op == OP_NOT);
    want = (op == OP_AND || op == OP_OR || op == OP_NOT) ? TY_BOOL : TY_INT;
    if ((op == OP_EQ || op == OP_NE) && ta == TY_BOOL) want = TY_BOOL;
    r.value = 64'd0;
    r.tag = TY_INT;
    r.status = ST_OK;
    if (depth < (unary ? 2'd1 : 2'd2)) begin
      r.status = ST_STATE;
    end else if (!operand_qualifies(ta, pa, a, want) ||
                 (!unary && !operand_qualifies(tb, pb, b, want))) begin
      r.status = ST_TYPE;
    end else begin
      if (unary) b = 64'd0;
      case (op)
        OP_ADD: r.value = a + b;
        OP_SUB: r.value = a - b;
        OP_MUL: r.value = a * b;
        OP_DIV, OP_REM: begin
          if (b == 64'd0) begin
            r.value = 64'd0;
          end else if (a == MinVal && b == AllOnes) begin
            r.value = (op == OP_DIV) ? MinVal : 64'd0;
          end else begin
            ua = a[63] ? -a : a;
            ub = b[63] ? -b : b;
            q = ua / ub;
            rm = ua % ub;
            if (op == OP_DIV) r.value = (a[63] != b[63]) ? -q : q;
            else r.value = a[63] ? -rm : rm;
          end
        end
        OP_NEG: r.value = -a;
        OP_EQ:  r.value = {63'd0, a == b};
        OP_NE:  r.value = {63'd0, a != b};
        OP_LT:  r.value = {63'd0, $signed(a) < $signed(b)};
        OP_LE:  r.value = {63'd0, $signed(a) <= $signed(b)};
        OP_GT:  r.value = {63'd0, $signed(a) > $signed(b)};
        OP_GE:  r.value = {63'd0, $signed(a) >= $signed(b)};
        OP_AND: r.value = {63'd0, a != 0 && b != 0};
        OP_OR:  r.value = {63'd0, a != 0 || b != 0};
        OP_NOT: r.value = {63'd0, a == 0};
        default: r.status = ST_STATE;
      endcase
      if (r.status == ST_OK && op >= OP_EQ) r.tag = TY_BOOL;
    end
    if (r.status != ST_OK) begin
      r.value = 64'd0;
      r.tag = TY_INT;
    end
    return r;
  endfunction

  // Sends one request and records the expected result once it is accepted.
  // The request stays offered after the transfer until the next one or an idle gap.
  task automatic send_op(func_e op, logic [63:0] a, logic [63:0] b, tag_e ta, tag_e tb,
                         logic pa, logic pb, logic [1:0] depth);
    int unsigned idle;
    idle = 0;
    while ($urandom_range(99) < send_idle_pct) idle++;
    if (idle != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (idle) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, depth, b, a, op};
    s_axis_tuser  <= {pb, pa, tb, ta};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    expected_results.push_back(alu_compute(op, a, b, ta, tb, pa, pb, depth));
  endtask

  // Stops offering requests and waits until every expected result has been delivered.
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Sends a well-typed operation with valid plain operands.
  task automatic send_typed(func_e op, logic [63:0] a, logic [63:0] b);
    tag_e t;
    t = (op == OP_AND || op == OP_OR || op == OP_NOT) ? TY_BOOL : TY_INT;
    send_op(op, a, b, t, t, 1'b1, 1'b1, 2'd2);
  endtask

  // Picks an operand value biased toward edge values.
  function automatic logic [63:0] pick_value();
    case ($urandom_range(7))
      0: return MinVal;
      1: return MaxVal;
      2: return AllOnes;
      3: return 64'd0;
      4: return 64'($signed($urandom_range(20)) - 10);
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // Directed cases: extremes, every operation and the error paths.
  task automatic test_directed();
    send_typed(OP_ADD, MaxVal, 64'd1);
    send_typed(OP_SUB, MinVal, 64'd1);
    send_typed(OP_MUL, MaxVal, MaxVal);
    send_typed(OP_DIV, MinVal, AllOnes);
    send_typed(OP_REM, MinVal, AllOnes);
    send_typed(OP_DIV, 64'd7, 64'd0);
    send_typed(OP_REM, 64'd7, 64'd0);
    send_typed(OP_DIV, -64'd7, 64'd2);
    send_typed(OP_REM, -64'd7, 64'd2);
    send_typed(OP_NEG, MinVal, 64'd5);
    send_typed(OP_EQ, AllOnes, AllOnes);
    send_typed(OP_NE, 64'd1, 64'd2);
    send_typed(OP_LT, MinVal, MaxVal);
    send_typed(OP_LE, MaxVal, MaxVal);
    send_typed(OP_GT, AllOnes, 64'd0);
    send_typed(OP_GE, MinVal, MinVal);
    send_typed(OP_AND, 64'd1, 64'd1);
    send_typed(OP_OR, 64'd0, 64'd0);
    send_typed(OP_NOT, 64'd0, AllOnes);
    send_typed(OP_INVALID, 64'd1, 64'd1);
    // Bool equality, bad bool value, missing operands, a wrong operand tag and depth field 3.
    send_op(OP_EQ, 64'd1, 64'd1, TY_BOOL, TY_BOOL, 1'b1, 1'b1, 2'd3);
    send_op(OP_AND, 64'd2, 64'd1, TY_BOOL, TY_BOOL, 1'b1, 1'b1, 2'd2);
    send_op(OP_ADD, 64'd1, 64'd1, TY_INT, TY_INT, 1'b1, 1'b1, 2'd1);
    send_op(OP_NEG, 64'd1, 64'd1, TY_INT, TY_VOID, 1'b1, 1'b0, 2'd0);
    send_op(OP_SUB, 64'd1, 64'd1, TY_INT, TY_OTHER, 1'b1, 1'b0, 2'd2);
    wait_drained();
  endtask

  // Random items, mostly well typed, the rest with random tags, flags and depth.
  task automatic test_random(int unsigned count);
    func_e       op;
    logic [63:0] a;
    logic [63:0] b;
    for (int unsigned i = 0; i < count; i++) begin
      op = func_e'($urandom_range(15));
      a = pick_value();
      b = pick_value();
      if ($urandom_range(99) < 75) begin
        if (op == OP_AND || op == OP_OR || op == OP_NOT ||
            ((op == OP_EQ || op == OP_NE) && $urandom_range(1))) begin
          a = 64'($urandom_range(1));
          b = 64'($urandom_range(1));
          send_op(op, a, b, TY_BOOL, TY_BOOL, 1'b1, 1'b1, 2'd2);
        end else begin
          send_typed(op, a, b);
        end
      end else begin
        send_op(op, a, b, tag_e'($urandom_range(3)), tag_e'($urandom_range(3)),
                1'($urandom), 1'($urandom), 2'($urandom));
      end
    end
  endtask

  // Long receiver hold-off while requests keep coming, then a full drain.
  // More items are sent than the pipeline and queue hold, so the input stalls.
  task automatic test_backpressure();
    hold_req++;
    test_random(150);
    wait_drained();
  endtask

  // Receiver side: random ready, with a counted hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      hold_done     <= 0;
      hold_cycles   <= 0;
    end else if (hold_cycles != 0) begin
      m_axis_tready <= 1'b0;
      hold_cycles   <= hold_cycles - 1;
    end else if (hold_done != hold_req) begin
      m_axis_tready <= 1'b0;
      hold_done     <= hold_req;
      hold_cycles   <= HoldLength;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Compares each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    alu_result_t exp_r;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        $error("unexpected result transfer: value %h", m_axis_tdata[63:0]);
        error_count++;
      end else begin
        exp_r = expected_results.pop_front();
        if (m_axis_tdata[63:0] !== exp_r.value) begin
          $error("result_value: expected %h, actual %h", exp_r.value, m_axis_tdata[63:0]);
          error_count++;
        end
        if (m_axis_tuser !== exp_r.tag) begin
          $error("result_tag: expected %0d, actual %0d", exp_r.tag, m_axis_tuser);
          error_count++;
        end
        if (m_axis_tdata[65:64] !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, m_axis_tdata[65:64]);
          error_count++;
        end
      end
    end
  end

  // Run watchdog.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("[vm_typed_int64_alu_core] ERROR");
      $finish;
    end
  end

  // Test sequence.
  initial begin
    error_count = 0;
    cycle_count = 0;
    hold_req = 0;
    send_idle_pct = 26;
    recv_idle_pct = 61;
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(300);
    send_idle_pct = 61;
    recv_idle_pct = 26;
    test_random(250);
    wait_drained();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_backpressure();
    test_random(200);
    wait_drained();
    repeat (DrainGap) @(posedge clk_i);
    if (error_count == 0) begin
      $display("[vm_typed_int64_alu_core] OK");
    end else begin
      $display("[vm_typed_int64_alu_core] ERROR");
    end
    $finish;
  end
endmodule
